// ===== hdl/rtd_pkg.sv =====
// ----------------------------------------------------------------------------
// rtd_pkg
// Types and constants shared by the roundabout tracker and deviation block.
// ----------------------------------------------------------------------------
package rtd_pkg;

	typedef enum logic [2:0] {
		MODE_NORMAL   = 3'd0,
		MODE_APPROACH = 3'd1,
		MODE_TURN_IN  = 3'd2,
		MODE_IN_LOOP  = 3'd3,
		MODE_EXITING  = 3'd4
	} mode_t;

	localparam logic [1:0] SIDE_NONE  = 2'd0;
	localparam logic [1:0] SIDE_LEFT  = 2'd1;
	localparam logic [1:0] SIDE_RIGHT = 2'd2;

	localparam logic [2:0] REG_ZONE_START   = 3'd0;
	localparam logic [2:0] REG_ZONE_END     = 3'd1;
	localparam logic [2:0] REG_COOLDOWN     = 3'd2;
	localparam logic [2:0] REG_ENTRY_LEN    = 3'd3;
	localparam logic [2:0] REG_TURN_IN_LEN  = 3'd4;
	localparam logic [2:0] REG_TURN_IN_ANG  = 3'd5;
	localparam logic [2:0] REG_EXIT_ANG     = 3'd6;
	localparam logic [2:0] REG_EXIT_XTRA    = 3'd7;

	// Weighted difference fits 19 bits signed (max |sub| ~ 33*4095)
	localparam int SUB_W = 24;
	localparam int ADD_W = 20;

	// Work item handed from the front to the back
	typedef struct packed {
		logic signed [SUB_W-1:0] sub;
		logic [ADD_W-1:0]        add;
		logic                    halt;
		logic [2:0]              ring_state;
		logic [1:0]              ring_side;
		logic                    clear_seg;
		logic                    seg_en;
	} work_t;

endpackage

// ===== hdl/roundabout_tracker_and_deviation.sv =====
// ----------------------------------------------------------------------------
// roundabout_tracker_and_deviation
// Roundabout tracker and difference-over-sum steering deviation.
// ----------------------------------------------------------------------------
// One beat in gives one beat out. The front steps the tracker, the stop latch
// and the weighted sums in the cycle the beat is taken and holds the work in
// a one-entry queue; the back runs a restoring divider at one bit per cycle.
// A beat passes the back as a load, 25 divide steps and an output step; the
// back takes no new beat till the output step is done; the front takes the
// next beat in the cycle the back loads the last. Configure only while idle.
module roundabout_tracker_and_deviation #(
	parameter int SAMPLE_BITS = 12,
	parameter int LOST_LIMIT  = 250
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_idx,
	input  logic [23:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [11:0]        left_outer,
	input  logic [11:0]        left_inner,
	input  logic [11:0]        center_coil,
	input  logic [11:0]        right_inner,
	input  logic [11:0]        right_outer,
	input  logic signed [15:0] yaw_rate,
	input  logic signed [15:0] pitch_rate,
	input  logic [23:0]        total_distance,
	input  logic [23:0]        segment_distance,
	input  logic               stop_request,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [7:0]  deviation,
	output logic               stopped,
	output logic [2:0]         ring_state,
	output logic [1:0]         ring_side,
	output logic               clear_segment,
	output logic               segment_enable
);
	logic w_valid, w_ready;
	rtd_pkg::work_t w_data;

	// Front: classify the tick and hold one work beat
	rtd_front #(.SAMPLE_BITS(SAMPLE_BITS), .LOST_LIMIT(LOST_LIMIT)) u_front (
		.clk, .arst_n, .cfg_we, .cfg_idx, .cfg_data, .in_valid, .in_ready,
		.lo_i(left_outer), .li_i(left_inner), .ce_i(center_coil),
		.ri_i(right_inner), .ro_i(right_outer), .yaw_i(yaw_rate),
		.pitch_i(pitch_rate), .total_i(total_distance), .seg_i(segment_distance),
		.stop_i(stop_request), .w_valid, .w_ready, .w_data
	);

	// Back: divide, clamp and present the result beat
	rtd_back u_back (
		.clk, .arst_n, .w_valid, .w_ready, .w_data, .out_valid, .out_ready,
		.deviation, .stopped, .ring_state, .ring_side, .clear_segment,
		.segment_enable
	);
endmodule

// ===== hdl/rtd_front.sv =====
// ----------------------------------------------------------------------------
// rtd_front
// Tracker state machine, stop logic and weighted sums; one tick per beat.
// ----------------------------------------------------------------------------
module rtd_front #(
	parameter int SAMPLE_BITS = 12,
	parameter int LOST_LIMIT  = 250
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_idx,
	input  logic [23:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [11:0]        lo_i, li_i, ce_i, ri_i, ro_i,
	input  logic signed [15:0] yaw_i, pitch_i,
	input  logic [23:0]        total_i, seg_i,
	input  logic               stop_i,
	output logic               w_valid,
	input  logic               w_ready,
	output rtd_pkg::work_t     w_data
);
	logic [23:0] zone_start_q, zone_end_q, cooldown_q, entry_len_q, turn_len_q;
	logic [15:0] turn_ang_q, exit_ang_q, exit_xtra_q;
	logic [2:0]  mode_q;
	logic [1:0]  side_q, deb_q;
	logic [7:0]  lost_q;
	logic        halt_q, dist_q, head_on_q;
	logic [31:0] head_q;

	// Compare thresholds scaled by 500; for exit: sum/500 > a  <=>  sum >= 500*(a+1)
	logic [31:0] turn_thr_q, exit_thr_q, xtra_thr_q;

	assign in_ready = w_ready;
	wire take = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zone_start_q <= 24'd600000; zone_end_q <= 24'd900000;
			cooldown_q <= 24'd12000; entry_len_q <= 24'd15000; turn_len_q <= 24'd13000;
			turn_ang_q <= 16'd600; exit_ang_q <= 16'd5300; exit_xtra_q <= 16'd420;
		end else if (cfg_we) begin
			case (cfg_idx)
				rtd_pkg::REG_ZONE_START:  zone_start_q <= cfg_data;
				rtd_pkg::REG_ZONE_END:    zone_end_q <= cfg_data;
				rtd_pkg::REG_COOLDOWN:    cooldown_q <= cfg_data;
				rtd_pkg::REG_ENTRY_LEN:   entry_len_q <= cfg_data;
				rtd_pkg::REG_TURN_IN_LEN: turn_len_q <= cfg_data;
				rtd_pkg::REG_TURN_IN_ANG: turn_ang_q <= cfg_data[15:0];
				rtd_pkg::REG_EXIT_ANG:    exit_ang_q <= cfg_data[15:0];
				rtd_pkg::REG_EXIT_XTRA:   exit_xtra_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// Threshold products registered off the config path (configured while idle)
	always_ff @(posedge clk) begin
		turn_thr_q <= 32'(turn_ang_q * 32'd500);
		exit_thr_q <= 32'((33'(exit_ang_q) + 33'd1) * 33'd500);
		xtra_thr_q <= 32'((33'(exit_xtra_q) + 33'd1) * 33'd500);
	end

	localparam logic [11:0] SMASK = 12'((1 << SAMPLE_BITS) - 1);
	logic [11:0] lo, li, ce, ri, ro;
	logic [15:0] ayaw, apitch;
	always_comb begin
		lo = lo_i & SMASK; li = li_i & SMASK; ce = ce_i & SMASK;
		ri = ri_i & SMASK; ro = ro_i & SMASK;
		ayaw   = yaw_i[15] ? 16'(-yaw_i) : yaw_i;
		apitch = pitch_i[15] ? 16'(-pitch_i) : pitch_i;
	end

	logic [2:0]  mode_n;
	logic [1:0]  side_n, deb_n;
	logic        dist_n, head_on_n, clr, halt_n;
	logic [7:0]  lost_n;
	logic [31:0] head_n, head_acc;
	logic [32:0] head_sum33;
	logic signed [rtd_pkg::SUB_W-1:0] sub;
	logic [rtd_pkg::ADD_W-1:0] add;
	logic signed [rtd_pkg::SUB_W-1:0] slo, sli, sri, sro;

	always_comb begin
		mode_n = mode_q; side_n = side_q; deb_n = deb_q; dist_n = dist_q;
		head_on_n = head_on_q; head_n = head_q; clr = 1'b0;
		slo = rtd_pkg::SUB_W'(lo); sli = rtd_pkg::SUB_W'(li);
		sri = rtd_pkg::SUB_W'(ri); sro = rtd_pkg::SUB_W'(ro);
		case (mode_q)
			rtd_pkg::MODE_NORMAL: begin
				if (total_i < zone_start_q || total_i > zone_end_q) deb_n = 2'd0;
				else if (dist_q && seg_i < cooldown_q) deb_n = 2'd0;
				else begin
					dist_n = 1'b0;
					if (ce > 12'd90 && (lo > 12'd80 || ri > 12'd80) && apitch < 16'd1500) begin
						deb_n = deb_q + 2'd1;
						if (deb_n >= 2'd2) begin
							mode_n = rtd_pkg::MODE_APPROACH; side_n = rtd_pkg::SIDE_NONE;
							clr = 1'b1; dist_n = 1'b1; deb_n = 2'd0;
						end
					end else deb_n = 2'd0;
				end
			end
			rtd_pkg::MODE_APPROACH: begin
				if (seg_i >= entry_len_q && ce > 12'd70 && (lo > 12'd60 || ri > 12'd60)) begin
					side_n = (13'(lo) + 13'(li) >= 13'(ri) + 13'(ro)) ?
						rtd_pkg::SIDE_LEFT : rtd_pkg::SIDE_RIGHT;
					mode_n = rtd_pkg::MODE_TURN_IN; clr = 1'b1; head_n = '0;
					head_on_n = 1'b1; dist_n = 1'b1;
				end
			end
			rtd_pkg::MODE_TURN_IN: begin
				if (head_q > turn_thr_q && ce < 12'd60 && seg_i > turn_len_q) begin
					mode_n = rtd_pkg::MODE_IN_LOOP; head_n = '0; clr = 1'b1;
					dist_n = 1'b0; head_on_n = 1'b1;
				end
			end
			rtd_pkg::MODE_IN_LOOP: begin
				if (head_q >= exit_thr_q) begin
					mode_n = rtd_pkg::MODE_EXITING; head_n = '0; head_on_n = 1'b1;
				end
			end
			rtd_pkg::MODE_EXITING: begin
				if (head_q >= xtra_thr_q) begin
					if (ce < 12'd80 && lo < 12'd60 && ri < 12'd60) begin
						mode_n = rtd_pkg::MODE_NORMAL; side_n = rtd_pkg::SIDE_NONE;
						deb_n = 2'd0; head_on_n = 1'b0; head_n = '0; clr = 1'b1;
						dist_n = 1'b1;
					end else deb_n = 2'd0;
				end
			end
			default: mode_n = rtd_pkg::MODE_NORMAL;
		endcase

		add = rtd_pkg::ADD_W'(lo) + rtd_pkg::ADD_W'(li) + rtd_pkg::ADD_W'(ce)
			+ rtd_pkg::ADD_W'(ri) + rtd_pkg::ADD_W'(ro) + rtd_pkg::ADD_W'(10);
		case (mode_n)
			rtd_pkg::MODE_APPROACH: sub = rtd_pkg::SUB_W'(10 * (sli - sro));
			rtd_pkg::MODE_TURN_IN: begin
				if (side_n == rtd_pkg::SIDE_RIGHT)
					sub = rtd_pkg::SUB_W'((2 * slo + 5 * sli) - (18 * sri + 15 * sro));
				else if (side_n == rtd_pkg::SIDE_LEFT)
					sub = rtd_pkg::SUB_W'((18 * slo + 15 * sli) - (2 * sri + 5 * sro));
				else sub = '0;
			end
			rtd_pkg::MODE_EXITING: begin
				if (side_n == rtd_pkg::SIDE_RIGHT)
					sub = rtd_pkg::SUB_W'(15 * (slo + sli) - 5 * (sri + sro));
				else sub = rtd_pkg::SUB_W'(5 * (slo + sli) - 15 * (sri + sro));
			end
			default: sub = rtd_pkg::SUB_W'(10 * ((slo + sli) - (sri + sro)));
		endcase

		halt_n = halt_q | stop_i;
		lost_n = lost_q;
		if (!halt_n) begin
			if (add < rtd_pkg::ADD_W'(20)) begin
				if (lost_q != 8'd255) lost_n = lost_q + 8'd1;
				if (lost_n >= 8'(LOST_LIMIT)) halt_n = 1'b1;
			end else lost_n = 8'd0;
		end

		head_sum33 = 33'(head_n) + 33'(ayaw);
		head_acc = head_sum33[32] ? 32'hFFFF_FFFF : head_sum33[31:0];
		if (head_on_n && ayaw > 16'd20) head_n = head_acc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= rtd_pkg::MODE_NORMAL; side_q <= rtd_pkg::SIDE_NONE; deb_q <= '0;
			lost_q <= '0; halt_q <= 1'b0; dist_q <= 1'b0; head_on_q <= 1'b0;
			head_q <= '0; w_valid <= 1'b0;
		end else begin
			if (w_ready) w_valid <= 1'b0;
			if (take) begin
				mode_q <= mode_n; side_q <= side_n; deb_q <= deb_n; lost_q <= lost_n;
				halt_q <= halt_n; dist_q <= dist_n; head_on_q <= head_on_n;
				head_q <= head_n; w_valid <= 1'b1;
			end
		end
	end

	// Zero the difference when already stopped or on a stop request; a stop that
	// the lost count latches on this tick still lets its own deviation through
	always_ff @(posedge clk) begin
		if (take) begin
			w_data.sub <= (halt_q | stop_i) ? '0 : sub;
			w_data.add <= add; w_data.halt <= halt_n;
			w_data.ring_state <= mode_n; w_data.ring_side <= side_n;
			w_data.clear_seg <= clr; w_data.seg_en <= dist_n;
		end
	end
endmodule

// ===== hdl/rtd_back.sv =====
// ----------------------------------------------------------------------------
// rtd_back
// Restoring divider for the deviation quotient, clamp and output register.
// ----------------------------------------------------------------------------
module rtd_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               w_valid,
	output logic               w_ready,
	input  rtd_pkg::work_t     w_data,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [7:0]  deviation,
	output logic               stopped,
	output logic [2:0]         ring_state,
	output logic [1:0]         ring_side,
	output logic               clear_segment,
	output logic               segment_enable
);
	// |sub|*10 / add: quotient > 100 clamps, so 8 quotient bits suffice
	localparam int QB = 8;
	localparam int NW = 25;
	typedef enum logic [2:0] {
		ST_IDLE = 3'b001, ST_DIV = 3'b010, ST_OUT = 3'b100
	} st_t;
	st_t st_q;
	logic [NW-1:0] num_q;
	logic [rtd_pkg::ADD_W-1:0] den_q;
	logic [NW:0] rem_q;
	logic [QB-1:0] quo_q;
	logic [4:0] cnt_q;
	logic neg_q, big_q, halt_q;
	logic [2:0] rs_q; logic [1:0] sd_q; logic cl_q, se_q;

	assign w_ready = (st_q == ST_IDLE);

	logic [NW-1:0] mag;
	logic [NW:0] trial;
	logic [NW:0] rem_sh;
	logic [7:0] sat;
	always_comb begin
		mag = w_data.sub[rtd_pkg::SUB_W-1] ? NW'(-w_data.sub) : NW'(w_data.sub);
		mag = NW'(mag * 10);
		rem_sh = {rem_q[NW-1:0], num_q[NW-1]};
		trial = rem_sh - (NW+1)'(den_q);
		sat = (big_q || quo_q > 8'd100) ? 8'd100 : quo_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE; out_valid <= 1'b0; cnt_q <= '0;
		end else begin
			case (st_q)
				ST_IDLE: if (w_valid) begin
					st_q <= ST_DIV; cnt_q <= 5'(NW);
				end
				ST_DIV: begin
					cnt_q <= cnt_q - 5'd1;
					if (cnt_q == 5'd1) st_q <= ST_OUT;
				end
				ST_OUT: if (!out_valid || out_ready) begin
					out_valid <= 1'b1; st_q <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
			if (out_valid && out_ready && st_q != ST_OUT) out_valid <= 1'b0;
		end
	end

	// Datapath: one quotient bit per cycle, top bits beyond QB flag overflow
	always_ff @(posedge clk) begin
		case (st_q)
			ST_IDLE: if (w_valid) begin
				num_q <= mag; den_q <= w_data.add; rem_q <= '0; quo_q <= '0;
				big_q <= 1'b0; neg_q <= w_data.sub[rtd_pkg::SUB_W-1];
				halt_q <= w_data.halt; rs_q <= w_data.ring_state;
				sd_q <= w_data.ring_side; cl_q <= w_data.clear_seg; se_q <= w_data.seg_en;
			end
			ST_DIV: begin
				num_q <= {num_q[NW-2:0], 1'b0};
				if (!trial[NW]) begin
					rem_q <= trial; big_q <= big_q | quo_q[QB-1];
					quo_q <= {quo_q[QB-2:0], 1'b1};
				end else begin
					rem_q <= rem_sh; big_q <= big_q | quo_q[QB-1];
					quo_q <= {quo_q[QB-2:0], 1'b0};
				end
			end
			ST_OUT: if (!out_valid || out_ready) begin
				deviation <= neg_q ? -$signed(sat) : $signed(sat);
				stopped <= halt_q; ring_state <= rs_q; ring_side <= sd_q;
				clear_segment <= cl_q; segment_enable <= se_q;
			end
			default: ;
		endcase
	end
endmodule

// ===== hdl/rtd_checker.sv =====
// ----------------------------------------------------------------------------
// rtd_checker
// Port-level checks on the tracker block.
// ----------------------------------------------------------------------------
module rtd_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              out_valid,
	input logic              out_ready,
	input logic signed [7:0] deviation,
	input logic              stopped,
	input logic [2:0]        ring_state,
	input logic [1:0]        ring_side
);
	a_dev_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (deviation <= 8'sd100 && deviation >= -8'sd100))
		else $error("deviation out of range");
	a_stop_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && stopped) |=> stopped)
		else $error("stop latch released");
	a_state_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (ring_state <= 3'd4 && ring_side != 2'd3))
		else $error("bad ring state or side");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(deviation)))
		else $error("result beat dropped");
endmodule

bind roundabout_tracker_and_deviation rtd_checker u_rtd_checker (
	.clk, .arst_n, .out_valid, .out_ready, .deviation, .stopped, .ring_state,
	.ring_side
);

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the roundabout tracker and deviation block: a
// behavioural tracker predicts each result beat, directed ticks walk the ring
// sequence, random ticks with random idling on both sides cover the rest.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int LOST_LIM = 250;

	typedef struct {
		logic [11:0] lo, li, ce, ri, ro;
		logic signed [15:0] yaw, pitch;
		logic [23:0] total, seg;
		logic stop;
	} tick_t;

	typedef struct {
		logic signed [7:0] dev;
		logic stopped;
		logic [2:0] rstate;
		logic [1:0] rside;
		logic clr;
		logic seg_en;
	} steer_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [2:0] cfg_idx = '0;
	logic [23:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [11:0] left_outer = '0, left_inner = '0, center_coil = '0;
	logic [11:0] right_inner = '0, right_outer = '0;
	logic signed [15:0] yaw_rate = '0, pitch_rate = '0;
	logic [23:0] total_distance = '0, segment_distance = '0;
	logic stop_request = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [7:0] deviation;
	logic stopped;
	logic [2:0] ring_state;
	logic [1:0] ring_side;
	logic clear_segment, segment_enable;

	roundabout_tracker_and_deviation uut (.*);

	always #5 clk = ~clk;

	// predictor copy of registers and tracker state
	logic [23:0] zone_lo, zone_hi, cool_len, entry_len, turn_len;
	logic [15:0] turn_ang, exit_ang, extra_ang;
	rtd_pkg::mode_t trk_mode;
	logic [1:0] trk_side;
	logic [1:0] debounce;
	logic [7:0] lost_cnt;
	logic halt, dist_on, head_on;
	logic [31:0] head_sum;

	tick_t pending_ticks[$];
	steer_t expected_steer[$];
	int errors = 0, beats_in = 0, beats_out = 0, ring_visits = 0, stops_seen = 0;
	bit quiet_tx = 0, quiet_rx = 0, hold_go = 0, hold_rx = 0, in_taken = 0;
	int hold_cnt = 0;

	task automatic write_reg(input logic [2:0] idx, input logic [23:0] val);
		@(negedge clk);
		cfg_we <= 1'b1; cfg_idx <= idx; cfg_data <= val;
		case (idx)
			rtd_pkg::REG_ZONE_START:  zone_lo = val;
			rtd_pkg::REG_ZONE_END:    zone_hi = val;
			rtd_pkg::REG_COOLDOWN:    cool_len = val;
			rtd_pkg::REG_ENTRY_LEN:   entry_len = val;
			rtd_pkg::REG_TURN_IN_LEN: turn_len = val;
			rtd_pkg::REG_TURN_IN_ANG: turn_ang = val[15:0];
			rtd_pkg::REG_EXIT_ANG:    exit_ang = val[15:0];
			default:                  extra_ang = val[15:0];
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Step the tracker, the stop latch and the deviation for one tick
	function automatic steer_t steer_predict(input tick_t t);
		longint lo, li, ce, ri, ro, sub, add, dv;
		longint ap, ay;
		logic clr;
		steer_t r;
		lo = t.lo; li = t.li; ce = t.ce; ri = t.ri; ro = t.ro;
		ap = (t.pitch < 0) ? -longint'(t.pitch) : longint'(t.pitch);
		ay = (t.yaw < 0) ? -longint'(t.yaw) : longint'(t.yaw);
		clr = 1'b0; dv = 0;
		case (trk_mode)
			rtd_pkg::MODE_NORMAL: begin
				if (t.total < zone_lo || t.total > zone_hi) debounce = 2'd0;
				else if (dist_on && t.seg < cool_len) debounce = 2'd0;
				else begin
					dist_on = 1'b0;
					if (ce > 90 && (lo > 80 || ri > 80) && ap < 1500) begin
						debounce = debounce + 2'd1;
						if (debounce >= 2'd2) begin
							trk_mode = rtd_pkg::MODE_APPROACH; trk_side = rtd_pkg::SIDE_NONE;
							clr = 1'b1; dist_on = 1'b1; debounce = 2'd0;
						end
					end else debounce = 2'd0;
				end
			end
			rtd_pkg::MODE_APPROACH: begin
				if (t.seg >= entry_len && ce > 70 && (lo > 60 || ri > 60)) begin
					trk_side = (lo + li >= ri + ro) ? rtd_pkg::SIDE_LEFT : rtd_pkg::SIDE_RIGHT;
					trk_mode = rtd_pkg::MODE_TURN_IN; clr = 1'b1; head_sum = '0;
					head_on = 1'b1; dist_on = 1'b1;
				end
			end
			rtd_pkg::MODE_TURN_IN: begin
				if (longint'(head_sum) > longint'(turn_ang) * 500 && ce < 60
						&& t.seg > turn_len) begin
					trk_mode = rtd_pkg::MODE_IN_LOOP; head_sum = '0; clr = 1'b1;
					dist_on = 1'b0; head_on = 1'b1;
				end
			end
			rtd_pkg::MODE_IN_LOOP: begin
				if (head_sum / 500 > exit_ang) begin
					trk_mode = rtd_pkg::MODE_EXITING; head_sum = '0; head_on = 1'b1;
				end
			end
			rtd_pkg::MODE_EXITING: begin
				if (head_sum / 500 > extra_ang) begin
					if (ce < 80 && lo < 60 && ri < 60) begin
						trk_mode = rtd_pkg::MODE_NORMAL; trk_side = rtd_pkg::SIDE_NONE;
						debounce = 2'd0; head_on = 1'b0; head_sum = '0; clr = 1'b1;
						dist_on = 1'b1;
					end else debounce = 2'd0;
				end
			end
			default: trk_mode = rtd_pkg::MODE_NORMAL;
		endcase
		if (t.stop) halt = 1'b1;
		if (!halt) begin
			add = lo + li + ce + ri + ro + 10;
			case (trk_mode)
				rtd_pkg::MODE_APPROACH: sub = 10 * (li - ro);
				rtd_pkg::MODE_TURN_IN: begin
					if (trk_side == rtd_pkg::SIDE_RIGHT)
						sub = (2*lo + 5*li) - (18*ri + 15*ro);
					else if (trk_side == rtd_pkg::SIDE_LEFT)
						sub = (18*lo + 15*li) - (2*ri + 5*ro);
					else sub = 0;
				end
				rtd_pkg::MODE_EXITING: begin
					if (trk_side == rtd_pkg::SIDE_RIGHT) sub = 15*(lo + li) - 5*(ri + ro);
					else sub = 5*(lo + li) - 15*(ri + ro);
				end
				default: sub = 10 * ((lo + li) - (ri + ro));
			endcase
			if (add < 20) begin
				if (lost_cnt < 8'd255) lost_cnt++;
				if (lost_cnt >= LOST_LIM) halt = 1'b1;
			end else lost_cnt = 8'd0;
			dv = (sub * 100) / (add * 10);
			if (dv > 100) dv = 100;
			if (dv < -100) dv = -100;
		end
		if (head_on && ay > 20) begin
			if (longint'(head_sum) + ay > 64'hFFFF_FFFF) head_sum = 32'hFFFF_FFFF;
			else head_sum = 32'(longint'(head_sum) + ay);
		end
		r.dev = dv[7:0]; r.stopped = halt; r.rstate = trk_mode; r.rside = trk_side;
		r.clr = clr; r.seg_en = dist_on;
		return r;
	endfunction

	// Driver: offer the head of the pending queue, advance on acceptance
	always @(negedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_taken) begin
				// hold the beat
			end else if (pending_ticks.size() > 0 && !(quiet_tx == 0 &&
					$urandom_range(99) < 22)) begin
				tick_t t;
				t = pending_ticks[0];
				in_valid <= 1'b1;
				left_outer <= t.lo; left_inner <= t.li; center_coil <= t.ce;
				right_inner <= t.ri; right_outer <= t.ro;
				yaw_rate <= t.yaw; pitch_rate <= t.pitch;
				total_distance <= t.total; segment_distance <= t.seg;
				stop_request <= t.stop;
			end else in_valid <= 1'b0;
			if (hold_rx) out_ready <= 1'b0;
			else out_ready <= quiet_rx || $urandom_range(99) >= 22;
		end
	end

	// Input side: predict each accepted beat
	always @(posedge clk) begin
		in_taken <= in_valid && in_ready;
		if (in_valid && in_ready) begin
			tick_t t;
			rtd_pkg::mode_t prev_mode;
			t = pending_ticks.pop_front();
			prev_mode = trk_mode;
			expected_steer.push_back(steer_predict(t));
			beats_in++;
			if (trk_mode == rtd_pkg::MODE_IN_LOOP && prev_mode != rtd_pkg::MODE_IN_LOOP)
				ring_visits++;
		end
	end

	// Monitor: compare each result beat with the oldest expectation
	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			steer_t e;
			beats_out++;
			if (expected_steer.size() == 0) begin
				$display("%0t: unexpected result beat", $time);
				errors++;
			end else begin
				e = expected_steer.pop_front();
				if (e.stopped) stops_seen++;
				if (deviation !== e.dev) begin
					$display("%0t: deviation exp %0d got %0d", $time, e.dev, deviation);
					errors++;
				end
				if (stopped !== e.stopped) begin
					$display("%0t: stopped exp %0b got %0b", $time, e.stopped, stopped);
					errors++;
				end
				if (ring_state !== e.rstate) begin
					$display("%0t: ring_state exp %0d got %0d", $time, e.rstate, ring_state);
					errors++;
				end
				if (ring_side !== e.rside) begin
					$display("%0t: ring_side exp %0d got %0d", $time, e.rside, ring_side);
					errors++;
				end
				if (clear_segment !== e.clr) begin
					$display("%0t: clear_segment exp %0b got %0b", $time, e.clr,
						clear_segment);
					errors++;
				end
				if (segment_enable !== e.seg_en) begin
					$display("%0t: segment_enable exp %0b got %0b", $time, e.seg_en,
						segment_enable);
					errors++;
				end
			end
		end
	end

	// Long receiver hold-off, counted in cycles
	always @(posedge clk) begin
		if (hold_go && hold_cnt < 300) begin
			hold_rx <= 1'b1;
			hold_cnt <= hold_cnt + 1;
		end else hold_rx <= 1'b0;
	end

	function automatic tick_t rand_tick(input int in_zone);
		tick_t t;
		t.lo = 12'($urandom); t.li = 12'($urandom); t.ce = 12'($urandom);
		t.ri = 12'($urandom); t.ro = 12'($urandom);
		if ($urandom_range(3) == 0) begin
			t.lo = 12'($urandom_range(150)); t.li = 12'($urandom_range(150));
			t.ce = 12'($urandom_range(150)); t.ri = 12'($urandom_range(150));
			t.ro = 12'($urandom_range(150));
		end
		t.yaw = 16'($urandom); t.pitch = 16'($urandom);
		if ($urandom_range(1)) t.pitch = 16'(int'($urandom_range(2999)) - 1500);
		t.total = in_zone ? 24'($urandom_range(900000, 600000)) : 24'($urandom);
		t.seg = 24'($urandom);
		t.stop = 1'b0;
		return t;
	endfunction

	function automatic tick_t mk(input int lo, li, ce, ri, ro, yaw, seg);
		tick_t t;
		t.lo = 12'(lo); t.li = 12'(li); t.ce = 12'(ce); t.ri = 12'(ri); t.ro = 12'(ro);
		t.yaw = 16'(yaw); t.pitch = '0; t.total = 24'd700000; t.seg = 24'(seg);
		t.stop = 1'b0;
		return t;
	endfunction

	// Queue one full ring pass with random content around the transitions
	task automatic queue_ring(input bit right_hand);
		int a, b;
		a = right_hand ? 100 : 400;
		b = right_hand ? 400 : 100;
		repeat (2) pending_ticks.push_back(mk(200, 100, 300, 200, 100, 0, 20000));
		pending_ticks.push_back(mk(a, a, 300, b, b, 1000, $urandom_range(3000)));
		pending_ticks.push_back(mk(a, a, 300, b, b, 1000, 16'hFFFF));
		repeat (4) pending_ticks.push_back(mk($urandom_range(4095), $urandom_range(4095),
			200, $urandom_range(4095), $urandom_range(4095), 30000, 100));
		pending_ticks.push_back(mk(50, 50, 30, 50, 50, 32767, 20000));
		repeat (3) pending_ticks.push_back(mk($urandom_range(800), 100, 100,
			$urandom_range(800), 100, -32768, 20000));
		repeat (2) pending_ticks.push_back(mk(100, 100, 100, 100, 100, -32768, 0));
		pending_ticks.push_back(mk(30, 30, 30, 30, 30, 5, 0));
	endtask

	task automatic drain();
		wait (pending_ticks.size() == 0 && expected_steer.size() == 0);
		repeat (40) @(posedge clk);
	endtask

	initial begin
		tick_t t;
		zone_lo = 600000; zone_hi = 900000; cool_len = 12000; entry_len = 15000;
		turn_len = 13000; turn_ang = 600; exit_ang = 5300; extra_ang = 420;
		trk_mode = rtd_pkg::MODE_NORMAL; trk_side = rtd_pkg::SIDE_NONE;
		debounce = 2'd0; lost_cnt = 8'd0;
		halt = 1'b0; dist_on = 1'b0; head_on = 1'b0; head_sum = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: small angles so the ring completes quickly
		write_reg(rtd_pkg::REG_TURN_IN_ANG, 1);
		write_reg(rtd_pkg::REG_EXIT_ANG, 2);
		write_reg(rtd_pkg::REG_EXIT_XTRA, 0);
		write_reg(rtd_pkg::REG_ENTRY_LEN, 10000);
		write_reg(rtd_pkg::REG_TURN_IN_LEN, 50);
		quiet_tx = 1; quiet_rx = 1;
		pending_ticks.push_back(mk(4095, 4095, 4095, 4095, 4095, 0, 0));
		pending_ticks.push_back(mk(4095, 0, 0, 0, 0, 0, 0));
		pending_ticks.push_back(mk(0, 0, 0, 0, 4095, 0, 0));
		queue_ring(0);
		queue_ring(1);
		drain();

		// Extremes of the registers, then random mix with idling
		write_reg(rtd_pkg::REG_ZONE_START, 0);
		write_reg(rtd_pkg::REG_ZONE_END, 24'hFFFFFF);
		write_reg(rtd_pkg::REG_COOLDOWN, 0);
		write_reg(rtd_pkg::REG_EXIT_ANG, 16'hFFFF);
		write_reg(rtd_pkg::REG_TURN_IN_ANG, 16'hFFFF);
		quiet_tx = 0; quiet_rx = 0;
		repeat (20) begin
			t = rand_tick(1);
			pending_ticks.push_back(t);
		end
		drain();

		write_reg(rtd_pkg::REG_ZONE_START, 600000);
		write_reg(rtd_pkg::REG_ZONE_END, 900000);
		write_reg(rtd_pkg::REG_COOLDOWN, 24'hFFFFFF);
		write_reg(rtd_pkg::REG_TURN_IN_ANG, 2);
		write_reg(rtd_pkg::REG_EXIT_ANG, 3);
		write_reg(rtd_pkg::REG_EXIT_XTRA, 16'hFFFF);
		write_reg(rtd_pkg::REG_ENTRY_LEN, 24'hFFFFFF);
		write_reg(rtd_pkg::REG_TURN_IN_LEN, 24'hFFFFFF);
		hold_go = 1;
		repeat (40) pending_ticks.push_back(rand_tick($urandom_range(1)));
		drain();

		write_reg(rtd_pkg::REG_COOLDOWN, 0);
		write_reg(rtd_pkg::REG_ENTRY_LEN, 0);
		write_reg(rtd_pkg::REG_TURN_IN_LEN, 0);
		write_reg(rtd_pkg::REG_EXIT_XTRA, 1);
		for (int k = 0; k < 4; k++) begin
			queue_ring(k[0]);
			repeat (4) pending_ticks.push_back(rand_tick($urandom_range(1)));
		end
		quiet_tx = 1; quiet_rx = 1;
		repeat (10) pending_ticks.push_back(rand_tick(1));
		drain();

		// Off-track run latching the stop, then an explicit stop request
		quiet_tx = 0; quiet_rx = 0;
		repeat (LOST_LIM + 2) pending_ticks.push_back(mk(1, 0, 2, 0, 1, 0, 0));
		t = rand_tick(1); t.stop = 1'b1; pending_ticks.push_back(t);
		repeat (10) pending_ticks.push_back(rand_tick(1));
		drain();

		$display("%0d ticks in, %0d results out; ring entered %0d times,",
			beats_in, beats_out, ring_visits);
		$display("%0d results with the stop latched", stops_seen);
		if (errors == 0) $display("** roundabout_tracker_and_deviation: PASSED **");
		else $display("** roundabout_tracker_and_deviation: FAILED **");
		$finish;
	end

	initial begin
		#5ms;
		$display("** roundabout_tracker_and_deviation: FAILED **");
		$finish;
	end

endmodule

// ===== roundabout_tracker_and_deviation.f =====
hdl/rtd_pkg.sv
hdl/rtd_front.sv
hdl/rtd_back.sv
hdl/roundabout_tracker_and_deviation.sv
hdl/rtd_checker.sv
tb/tb_top.sv
